FILE: design/otli_pkg.sv
// ----------------------------------------------------------------------------
// otli_pkg - shared types and constants of the orbit table interpolator
// Field widths, table geometry, opcode and status codes, the queue entry
// passed from the front end to the back end, and the divider step.
// ----------------------------------------------------------------------------
package otli_pkg;

	localparam int WINDOWS = 1024;
	localparam int LINKS   = 6;
	localparam int CRAFT   = 3;
	localparam int DIMS    = 3;

	localparam int TIME_W = 40;
	localparam int DT_W   = 25;
	localparam int CNT_W  = 11;
	localparam int VAL_W  = 48;
	localparam int ADDR_W = 15;
	localparam int CODE_W = 7;
	localparam int UNIT_W = 3;

	localparam int W_BITS    = $clog2(WINDOWS);
	localparam int CNT_EFF_W = (CNT_W > $clog2(WINDOWS + 1)) ? CNT_W : $clog2(WINDOWS + 1);

	localparam int POS_ROWS  = WINDOWS * CRAFT;
	localparam int NRM_ROWS  = WINDOWS * LINKS;
	localparam int POS_RB    = $clog2(POS_ROWS);
	localparam int NRM_RB    = $clog2(NRM_ROWS);
	localparam int POS_DEPTH = POS_ROWS * DIMS;
	localparam int NRM_DEPTH = NRM_ROWS * DIMS;
	localparam int LTT_DEPTH = NRM_ROWS;

	// difference of two samples, its magnitude, and the divider geometry
	localparam int DIFF_W    = VAL_W + 1;
	localparam int LO_W      = 24;
	localparam int HI_W      = VAL_W - LO_W;
	localparam int QUO_W     = VAL_W;
	localparam int DVD_W     = QUO_W + DT_W;
	localparam int DIV_STEPS = QUO_W;
	localparam int DIV_LAT   = DIV_STEPS + 1;

	// address / 3 as (addr * DIV3_MUL) >> DIV3_SH, exact over the address range
	localparam int DIV3_MUL = 21846;
	localparam int DIV3_SH  = 16;
	localparam int ROW3_W   = ADDR_W - 1;

	localparam logic [CODE_W-1:0] LINK_CODE [LINKS] = '{
		7'd12, 7'd23, 7'd31, 7'd13, 7'd32, 7'd21
	};

	localparam logic [1:0] TS_POS = 2'd0;
	localparam logic [1:0] TS_NRM = 2'd1;
	localparam logic [1:0] TS_LTT = 2'd2;

	localparam int  CFG_ADDR_W = 3;
	localparam int  CFG_IDX_B  = 2;
	localparam logic REG_WLEN  = 1'b0;
	localparam logic REG_WCNT  = 1'b1;
	localparam logic [DT_W-1:0]  WLEN_RST = 25'd1024;
	localparam logic [CNT_W-1:0] WCNT_RST = 11'd1024;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_POS   = 2'd1,
		OP_NRM   = 2'd2,
		OP_LTT   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_CODE  = 2'd2,
		ST_WRITE = 2'd3
	} st_t;

	typedef struct packed {
		logic              is_wr;
		op_t               op;
		st_t               st;
		logic [W_BITS-1:0] w;
		logic [DT_W-1:0]   frac;
		logic [UNIT_W-1:0] unit;
		logic              wr_en;
		logic [1:0]        wr_sel;
		logic [NRM_RB-1:0] wr_row;
		logic [1:0]        wr_comp;
		logic [VAL_W-1:0]  wr_val;
	} mid_t;

	typedef struct packed {
		logic [VAL_W-1:0] x;
		logic [VAL_W-1:0] y;
		logic [VAL_W-1:0] z;
		st_t              st;
	} res_t;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	function automatic logic [DT_W+QUO_W-1:0] div_step(
		input logic [DT_W-1:0]  rem,
		input logic [QUO_W-1:0] low,
		input logic [DT_W-1:0]  dt
	);
		logic [DT_W:0] sh;
		logic          qb;
		sh = {rem, low[QUO_W-1]};
		qb = 1'b0;
		if (sh >= {1'b0, dt}) begin
			sh = sh - {1'b0, dt};
			qb = 1'b1;
		end
		return {sh[DT_W-1:0], low[QUO_W-2:0], qb};
	endfunction

endpackage

FILE: design/orbit_table_linear_interpolator_core.sv
// ----------------------------------------------------------------------------
// orbit_table_linear_interpolator_core - sampled orbit table interpolator
// Top level: configuration registers, front end and back end.
// ----------------------------------------------------------------------------
// Holds craft position, link normal and link light travel time tables, loaded
// one 48-bit word per write transaction (opcode 0), and answers queries
// (opcodes 1..3) with values linearly interpolated between samples window and
// window+1, where window = time_req / window_len rounded down; the correction
// is rounded to nearest with ties away from zero. Both sides behave as queues:
// a transaction is taken on push with full low and a result leaves on pop with
// empty low, one transaction per clock in each direction while nothing
// stalls, results in input order. The path from accept to result runs through
// two 48-step restoring divider pipelines in series (window split in the front
// end, interpolation correction in the back end) plus table read, multiply
// and rounding stages. The front end and back end are parted by a four-entry
// queue, so a stalled result side holds the back end first and the front end
// only once that queue has filled. Tables come up undefined with no clearing
// pass; a query must only touch written words. window_len and window_count
// are written over the APB port; the user must write them only while the block
// is idle, the block does not enforce it. A window_len of zero acts as one.
// ----------------------------------------------------------------------------
module orbit_table_linear_interpolator_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// query / write transactions
	input  logic                                push,
	output logic                                full,
	input  logic [1:0]                          opcode,
	input  logic [otli_pkg::TIME_W-1:0]         time_req,
	input  logic [otli_pkg::CODE_W-1:0]         unit_code,
	input  logic [1:0]                          table_select,
	input  logic [otli_pkg::ADDR_W-1:0]         table_address,
	input  logic signed [otli_pkg::VAL_W-1:0]   write_value,
	// results
	output logic                                empty,
	input  logic                                pop,
	output logic signed [otli_pkg::VAL_W-1:0]   x_value,
	output logic signed [otli_pkg::VAL_W-1:0]   y_value,
	output logic signed [otli_pkg::VAL_W-1:0]   z_value,
	output logic [1:0]                          status,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [otli_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	logic [otli_pkg::DT_W-1:0]  wlen_q;
	logic [otli_pkg::CNT_W-1:0] wcnt_q;
	logic [otli_pkg::DT_W-1:0]  dt_eff;
	logic                       hd_vld;
	otli_pkg::mid_t             hd;
	logic                       hd_pop;

	assign pready = 1'b1;

	// config registers, written in the APB access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= otli_pkg::WLEN_RST;
			wcnt_q <= otli_pkg::WCNT_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[otli_pkg::CFG_IDX_B])
				otli_pkg::REG_WLEN: wlen_q <= pwdata[otli_pkg::DT_W-1:0];
				otli_pkg::REG_WCNT: wcnt_q <= pwdata[otli_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[otli_pkg::CFG_IDX_B])
			otli_pkg::REG_WLEN: prdata = {{(32 - otli_pkg::DT_W){1'b0}}, wlen_q};
			otli_pkg::REG_WCNT: prdata = {{(32 - otli_pkg::CNT_W){1'b0}}, wcnt_q};
			default:            prdata = '0;
		endcase
	end

	// a zero spacing divides as one
	assign dt_eff = (wlen_q == '0) ? otli_pkg::DT_W'(1) : wlen_q;

	// front end: window = time / spacing, range and code checks, write decode
	otli_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.opcode        (opcode),
		.time_req      (time_req),
		.unit_code     (unit_code),
		.table_select  (table_select),
		.table_address (table_address),
		.write_value   (write_value),
		.dt            (dt_eff),
		.cnt           (wcnt_q),
		.hd_vld        (hd_vld),
		.hd            (hd),
		.hd_pop        (hd_pop)
	);

	// back end: tables, interpolation, result queue
	otli_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.hd_vld  (hd_vld),
		.hd      (hd),
		.hd_pop  (hd_pop),
		.dt      (dt_eff),
		.empty   (empty),
		.pop     (pop),
		.x_value (x_value),
		.y_value (y_value),
		.z_value (z_value),
		.status  (status)
	);

endmodule

FILE: design/otli_div.sv
// ----------------------------------------------------------------------------
// otli_div - pipelined restoring divider
// One quotient bit per stage; takes a new dividend every enabled cycle.
// The top DT_W dividend bits must already be below the divisor.
// ----------------------------------------------------------------------------
module otli_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [otli_pkg::DVD_W-1:0]    dvd,
	input  logic [otli_pkg::DT_W-1:0]     dt,
	output logic [otli_pkg::QUO_W-1:0]    quo,
	output logic [otli_pkg::DT_W-1:0]     rem
);

	logic [otli_pkg::DT_W-1:0]  rem_s [otli_pkg::DIV_STEPS+1];
	logic [otli_pkg::QUO_W-1:0] low_s [otli_pkg::DIV_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= dvd[otli_pkg::DVD_W-1 -: otli_pkg::DT_W];
			low_s[0] <= dvd[otli_pkg::QUO_W-1:0];
			for (int i = 0; i < otli_pkg::DIV_STEPS; i++) begin
				{rem_s[i+1], low_s[i+1]} <= otli_pkg::div_step(rem_s[i], low_s[i], dt);
			end
		end
	end

	assign quo = low_s[otli_pkg::DIV_STEPS];
	assign rem = rem_s[otli_pkg::DIV_STEPS];

endmodule

FILE: design/otli_front.sv
// ----------------------------------------------------------------------------
// otli_front - input side: window divide, classification, hand-off queue
// Splits the query time into window and fraction, checks range and unit code,
// decodes table writes, and queues the result for the back end.
// ----------------------------------------------------------------------------
module otli_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [1:0]                      opcode,
	input  logic [otli_pkg::TIME_W-1:0]     time_req,
	input  logic [otli_pkg::CODE_W-1:0]     unit_code,
	input  logic [1:0]                      table_select,
	input  logic [otli_pkg::ADDR_W-1:0]     table_address,
	input  logic signed [otli_pkg::VAL_W-1:0] write_value,
	input  logic [otli_pkg::DT_W-1:0]       dt,
	input  logic [otli_pkg::CNT_W-1:0]      cnt,
	output logic                            hd_vld,
	output otli_pkg::mid_t                  hd,
	input  logic                            hd_pop
);

	localparam int QD   = 4;
	localparam int QP_W = $clog2(QD);
	localparam int QC_W = $clog2(QD + 1);

	typedef struct packed {
		otli_pkg::op_t               op;
		logic [otli_pkg::CODE_W-1:0] code;
		logic [1:0]                  sel;
		logic [otli_pkg::ADDR_W-1:0] addr;
		logic [otli_pkg::VAL_W-1:0]  val;
	} fsb_t;

	logic                        en;
	logic [otli_pkg::QUO_W-1:0]  quo;
	logic [otli_pkg::DT_W-1:0]   rem;
	logic                        vld_s [otli_pkg::DIV_LAT];
	fsb_t                        sb_s  [otli_pkg::DIV_LAT];
	fsb_t                        sb;
	otli_pkg::mid_t              cls;
	logic                        vld_c1;
	otli_pkg::mid_t              ent_c1;
	logic [otli_pkg::CNT_EFF_W-1:0] cnt_eff;
	logic                        oor;
	logic                        code_ok;
	logic [otli_pkg::UNIT_W-1:0] unit;
	logic [otli_pkg::ADDR_W+otli_pkg::DIV3_SH-1:0] row3_p;
	logic [otli_pkg::ROW3_W-1:0] row3;
	logic [otli_pkg::ADDR_W-1:0] comp_t;
	otli_pkg::mid_t              q_mem_q [QD];
	logic [QP_W-1:0]             wp_q;
	logic [QP_W-1:0]             rp_q;
	logic [QC_W-1:0]             cnt_q;
	logic                        q_full;
	logic                        q_push;

	assign q_full = (cnt_q == QC_W'(QD));
	assign en     = !q_full;
	assign full   = q_full;

	otli_div u_div (
		.clk (clk),
		.en  (en),
		.dvd ({{(otli_pkg::DVD_W - otli_pkg::TIME_W){1'b0}}, time_req}),
		.dt  (dt),
		.quo (quo),
		.rem (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < otli_pkg::DIV_LAT; i++) vld_s[i] <= 1'b0;
			vld_c1 <= 1'b0;
		end else if (en) begin
			vld_s[0] <= push;
			for (int i = 1; i < otli_pkg::DIV_LAT; i++) vld_s[i] <= vld_s[i-1];
			vld_c1 <= vld_s[otli_pkg::DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s[0] <= '{op: otli_pkg::op_t'(opcode), code: unit_code, sel: table_select,
				addr: table_address, val: write_value};
			for (int i = 1; i < otli_pkg::DIV_LAT; i++) sb_s[i] <= sb_s[i-1];
			ent_c1 <= cls;
		end
	end

	assign cnt_eff = (32'(cnt) > otli_pkg::WINDOWS) ? otli_pkg::CNT_EFF_W'(otli_pkg::WINDOWS)
		: otli_pkg::CNT_EFF_W'(cnt);

	always_comb begin
		sb      = sb_s[otli_pkg::DIV_LAT-1];
		oor     = ({1'b0, quo} + (otli_pkg::QUO_W+1)'(1)) >= (otli_pkg::QUO_W+1)'(cnt_eff);
		code_ok = 1'b0;
		unit    = '0;
		case (sb.op)
			otli_pkg::OP_POS: begin
				if (sb.code >= 7'd1 && sb.code <= otli_pkg::CODE_W'(otli_pkg::CRAFT)) begin
					code_ok = 1'b1;
					unit    = otli_pkg::UNIT_W'(sb.code - 7'd1);
				end
			end
			otli_pkg::OP_NRM, otli_pkg::OP_LTT: begin
				for (int k = 0; k < otli_pkg::LINKS; k++) begin
					if (otli_pkg::LINK_CODE[k] == sb.code) begin
						code_ok = 1'b1;
						unit    = otli_pkg::UNIT_W'(k);
					end
				end
			end
			default: ;
		endcase

		// word address -> row and component by multiply with the reciprocal of 3
		row3_p = {{otli_pkg::DIV3_SH{1'b0}}, sb.addr}
			* (otli_pkg::ADDR_W+otli_pkg::DIV3_SH)'(otli_pkg::DIV3_MUL);
		row3   = row3_p[otli_pkg::DIV3_SH +: otli_pkg::ROW3_W];
		comp_t = sb.addr - otli_pkg::ADDR_W'(32'(row3) * 3);

		cls         = '0;
		cls.op      = sb.op;
		cls.is_wr   = (sb.op == otli_pkg::OP_WRITE);
		cls.w       = quo[otli_pkg::W_BITS-1:0];
		cls.frac    = rem;
		cls.unit    = unit;
		cls.wr_sel  = sb.sel;
		cls.wr_val  = sb.val;
		cls.wr_comp = comp_t[1:0];
		cls.wr_row  = otli_pkg::NRM_RB'(row3);
		case (sb.sel)
			otli_pkg::TS_POS: cls.wr_en = 32'(sb.addr) < otli_pkg::POS_DEPTH;
			otli_pkg::TS_NRM: cls.wr_en = 32'(sb.addr) < otli_pkg::NRM_DEPTH;
			otli_pkg::TS_LTT: begin
				cls.wr_en   = 32'(sb.addr) < otli_pkg::LTT_DEPTH;
				cls.wr_row  = otli_pkg::NRM_RB'(sb.addr);
				cls.wr_comp = 2'd0;
			end
			default: cls.wr_en = 1'b0;
		endcase

		// range is checked before the code
		if (cls.is_wr)
			cls.st = otli_pkg::ST_WRITE;
		else if (oor)
			cls.st = otli_pkg::ST_RANGE;
		else if (!code_ok)
			cls.st = otli_pkg::ST_CODE;
		else
			cls.st = otli_pkg::ST_OK;
	end

	// hand-off queue
	assign q_push = en && vld_c1;

	always_ff @(posedge clk) begin
		if (q_push) q_mem_q[wp_q] <= ent_c1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (q_push) wp_q <= wp_q + QP_W'(1);
			if (hd_pop) rp_q <= rp_q + QP_W'(1);
			if (q_push && !hd_pop)
				cnt_q <= cnt_q + QC_W'(1);
			else if (!q_push && hd_pop)
				cnt_q <= cnt_q - QC_W'(1);
		end
	end

	assign hd_vld = (cnt_q != '0);
	assign hd     = q_mem_q[rp_q];

endmodule

FILE: design/otli_back.sv
// ----------------------------------------------------------------------------
// otli_back - table memories, interpolation datapath and result queue
// Reads both samples per component, forms the rounded correction
// diff * frac / window_len through a pipelined divider, queues the result.
// ----------------------------------------------------------------------------
module otli_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              hd_vld,
	input  otli_pkg::mid_t                    hd,
	output logic                              hd_pop,
	input  logic [otli_pkg::DT_W-1:0]         dt,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [otli_pkg::VAL_W-1:0] x_value,
	output logic signed [otli_pkg::VAL_W-1:0] y_value,
	output logic signed [otli_pkg::VAL_W-1:0] z_value,
	output logic [1:0]                        status
);

	localparam int OD   = 4;
	localparam int OP_W = $clog2(OD);
	localparam int OC_W = $clog2(OD + 1);
	localparam int VW   = otli_pkg::VAL_W;

	typedef struct packed {
		otli_pkg::st_t         st;
		logic [2:0]            neg;
		logic [2:0][VW-1:0]    dn;
	} bsb_t;

	logic [VW-1:0] pos_mem [otli_pkg::DIMS][otli_pkg::POS_ROWS];
	logic [VW-1:0] nrm_mem [otli_pkg::DIMS][otli_pkg::NRM_ROWS];
	logic [VW-1:0] ltt_mem [otli_pkg::NRM_ROWS];

	logic                      en;
	logic [otli_pkg::POS_RB-1:0] prow_dn, prow_up;
	logic [otli_pkg::NRM_RB-1:0] nrow_dn, nrow_up;

	logic                      v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	otli_pkg::op_t             op_s1;
	otli_pkg::st_t             st_s1, st_s2, st_s3, st_s4, st_s5, st_s6;
	logic [otli_pkg::DT_W-1:0] frac_s1, frac_s2, frac_s3;
	logic [VW-1:0]             pdn_s1 [3];
	logic [VW-1:0]             pup_s1 [3];
	logic [VW-1:0]             ndn_s1 [3];
	logic [VW-1:0]             nup_s1 [3];
	logic [VW-1:0]             ldn_s1, lup_s1;
	logic [VW-1:0]             dn [3];
	logic [VW-1:0]             up [3];
	logic [VW-1:0]             dn_s2 [3];
	logic [VW-1:0]             dn_s3 [3];
	logic [VW-1:0]             dn_s4 [3];
	logic [VW-1:0]             dn_s5 [3];
	logic [VW-1:0]             dn_s6 [3];
	logic [otli_pkg::DIFF_W-1:0] diff_s2 [3];
	logic [otli_pkg::DIFF_W-1:0] ndiff [3];
	logic [2:0]                neg_s3, neg_s4, neg_s5, neg_s6;
	logic [VW-1:0]             mag_s3 [3];
	logic [otli_pkg::HI_W+otli_pkg::DT_W-1:0] phi_s4 [3];
	logic [otli_pkg::LO_W+otli_pkg::DT_W-1:0] plo_s4 [3];
	logic [otli_pkg::DVD_W-1:0] prod_s5 [3];
	logic [otli_pkg::QUO_W-1:0] quo [3];
	logic [otli_pkg::DT_W-1:0]  rem [3];
	logic [VW-1:0]             qr_s6 [3];
	logic                      bv_s [otli_pkg::DIV_LAT];
	bsb_t                      bsb_s [otli_pkg::DIV_LAT];
	bsb_t                      bsb;
	logic [VW-1:0]             rv [3];

	otli_pkg::res_t            o_mem_q [OD];
	logic [OP_W-1:0]           owp_q, orp_q;
	logic [OC_W-1:0]           ocnt_q;
	logic                      o_full, o_push, o_pop;
	otli_pkg::res_t            o_head;

	assign o_full = (ocnt_q == OC_W'(OD));
	assign en     = !o_full;
	assign hd_pop = en && hd_vld;

	// rows of sample window and window+1
	assign prow_dn = otli_pkg::POS_RB'(32'(hd.w) * otli_pkg::CRAFT + 32'(hd.unit));
	assign prow_up = otli_pkg::POS_RB'(32'(hd.w) * otli_pkg::CRAFT + 32'(hd.unit)
		+ otli_pkg::CRAFT);
	assign nrow_dn = otli_pkg::NRM_RB'(32'(hd.w) * otli_pkg::LINKS + 32'(hd.unit));
	assign nrow_up = otli_pkg::NRM_RB'(32'(hd.w) * otli_pkg::LINKS + 32'(hd.unit)
		+ otli_pkg::LINKS);

	// table writes and reads happen in queue order at the same stage
	always_ff @(posedge clk) begin
		if (en) begin
			if (hd_vld && hd.is_wr && hd.wr_en) begin
				case (hd.wr_sel)
					otli_pkg::TS_POS:
						pos_mem[hd.wr_comp][hd.wr_row[otli_pkg::POS_RB-1:0]] <= hd.wr_val;
					otli_pkg::TS_NRM: nrm_mem[hd.wr_comp][hd.wr_row] <= hd.wr_val;
					otli_pkg::TS_LTT: ltt_mem[hd.wr_row] <= hd.wr_val;
					default: ;
				endcase
			end
			for (int c = 0; c < 3; c++) begin
				pdn_s1[c] <= pos_mem[c][prow_dn];
				pup_s1[c] <= pos_mem[c][prow_up];
				ndn_s1[c] <= nrm_mem[c][nrow_dn];
				nup_s1[c] <= nrm_mem[c][nrow_up];
			end
			ldn_s1  <= ltt_mem[nrow_dn];
			lup_s1  <= ltt_mem[nrow_up];
			op_s1   <= hd.op;
			st_s1   <= hd.st;
			frac_s1 <= hd.frac;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			dn[c] = '0;
			up[c] = '0;
		end
		case (op_s1)
			otli_pkg::OP_POS: begin
				for (int c = 0; c < 3; c++) begin
					dn[c] = pdn_s1[c];
					up[c] = pup_s1[c];
				end
			end
			otli_pkg::OP_NRM: begin
				for (int c = 0; c < 3; c++) begin
					dn[c] = ndn_s1[c];
					up[c] = nup_s1[c];
				end
			end
			otli_pkg::OP_LTT: begin
				dn[0] = ldn_s1;
				up[0] = lup_s1;
			end
			default: ;
		endcase
		for (int c = 0; c < 3; c++) ndiff[c] = -diff_s2[c];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				// s2: signed difference
				diff_s2[c] <= {up[c][VW-1], up[c]} - {dn[c][VW-1], dn[c]};
				dn_s2[c]   <= dn[c];
				// s3: sign and magnitude
				neg_s3[c]  <= diff_s2[c][otli_pkg::DIFF_W-1];
				mag_s3[c]  <= diff_s2[c][otli_pkg::DIFF_W-1] ? ndiff[c][VW-1:0]
					: diff_s2[c][VW-1:0];
				dn_s3[c]   <= dn_s2[c];
				// s4: two partial products
				phi_s4[c]  <= mag_s3[c][VW-1 -: otli_pkg::HI_W] * frac_s3;
				plo_s4[c]  <= mag_s3[c][otli_pkg::LO_W-1:0] * frac_s3;
				dn_s4[c]   <= dn_s3[c];
				// s5: full product
				prod_s5[c] <= {phi_s4[c], {otli_pkg::LO_W{1'b0}}}
					+ otli_pkg::DVD_W'(plo_s4[c]);
				dn_s5[c]   <= dn_s4[c];
			end
			st_s2   <= st_s1;
			frac_s2 <= frac_s1;
			st_s3   <= st_s2;
			frac_s3 <= frac_s2;
			neg_s4  <= neg_s3;
			st_s4   <= st_s3;
			neg_s5  <= neg_s4;
			st_s5   <= st_s4;
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		otli_div u_div (
			.clk (clk),
			.en  (en),
			.dvd (prod_s5[g]),
			.dt  (dt),
			.quo (quo[g]),
			.rem (rem[g])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bsb_s[0] <= '{st: st_s5, neg: neg_s5, dn: {dn_s5[2], dn_s5[1], dn_s5[0]}};
			for (int i = 1; i < otli_pkg::DIV_LAT; i++) bsb_s[i] <= bsb_s[i-1];
			// s6: round half away from zero on the magnitude
			for (int c = 0; c < 3; c++) begin
				qr_s6[c] <= quo[c] + VW'({rem[c], 1'b0} >= {1'b0, dt});
				dn_s6[c] <= bsb.dn[c];
			end
			neg_s6 <= bsb.neg;
			st_s6  <= bsb.st;
		end
	end

	assign bsb = bsb_s[otli_pkg::DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int i = 0; i < otli_pkg::DIV_LAT; i++) bv_s[i] <= 1'b0;
		end else if (en) begin
			v_s1 <= hd_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			bv_s[0] <= v_s5;
			for (int i = 1; i < otli_pkg::DIV_LAT; i++) bv_s[i] <= bv_s[i-1];
			v_s6 <= bv_s[otli_pkg::DIV_LAT-1];
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (st_s6 != otli_pkg::ST_OK)
				rv[c] = '0;
			else if (neg_s6[c])
				rv[c] = dn_s6[c] - qr_s6[c];
			else
				rv[c] = dn_s6[c] + qr_s6[c];
		end
	end

	// result queue
	assign o_push = en && v_s6;
	assign o_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (o_push) o_mem_q[owp_q] <= '{x: rv[0], y: rv[1], z: rv[2], st: st_s6};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (o_push) owp_q <= owp_q + OP_W'(1);
			if (o_pop) orp_q <= orp_q + OP_W'(1);
			if (o_push && !o_pop)
				ocnt_q <= ocnt_q + OC_W'(1);
			else if (!o_push && o_pop)
				ocnt_q <= ocnt_q - OC_W'(1);
		end
	end

	assign o_head  = o_mem_q[orp_q];
	assign empty   = (ocnt_q == '0);
	assign x_value = o_head.x;
	assign y_value = o_head.y;
	assign z_value = o_head.z;
	assign status  = o_head.st;

endmodule

FILE: design/otli_chk.sv
// ----------------------------------------------------------------------------
// otli_chk - port-level checks of the interpolator
// Result holding, zeroed error and write results, reset state and register readback.
// ----------------------------------------------------------------------------
module otli_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              push,
	input logic                              full,
	input logic [1:0]                        opcode,
	input logic [otli_pkg::TIME_W-1:0]       time_req,
	input logic [otli_pkg::CODE_W-1:0]       unit_code,
	input logic [1:0]                        table_select,
	input logic [otli_pkg::ADDR_W-1:0]       table_address,
	input logic signed [otli_pkg::VAL_W-1:0] write_value,
	input logic                              empty,
	input logic                              pop,
	input logic signed [otli_pkg::VAL_W-1:0] x_value,
	input logic signed [otli_pkg::VAL_W-1:0] y_value,
	input logic signed [otli_pkg::VAL_W-1:0] z_value,
	input logic [1:0]                        status,
	input logic                              psel,
	input logic                              penable,
	input logic                              pwrite,
	input logic [otli_pkg::CFG_ADDR_W-1:0]   paddr,
	input logic [31:0]                       pwdata,
	input logic [31:0]                       prdata,
	input logic                              pready
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(x_value) && $stable(y_value)
			&& $stable(z_value) && $stable(status)))
		else $error("result changed while stalled");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != otli_pkg::ST_OK) |-> (x_value == '0 && y_value == '0
			&& z_value == '0))
		else $error("error or write result carries nonzero data");

	a_rst: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> (empty && !full))
		else $error("queues not empty after reset");

	a_rdbk: assert property (@(posedge clk) disable iff (!arst_n)
		($past(psel && penable && pwrite && pready
			&& paddr[otli_pkg::CFG_IDX_B] == otli_pkg::REG_WCNT)
			&& psel && !pwrite && paddr[otli_pkg::CFG_IDX_B] == otli_pkg::REG_WCNT)
		|-> (prdata == {{(32 - otli_pkg::CNT_W){1'b0}}, $past(pwdata[otli_pkg::CNT_W-1:0])}))
		else $error("window_count readback mismatch");

endmodule

bind orbit_table_linear_interpolator_core otli_chk u_chk (.*);
